// ===== hdl/fmmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmmp_pkg
// shared widths, constants, types and state codes for the fibonacci
// mod-m matrix power block
// ----------------------------------------------------------------------------
package fmmp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MOD_WIDTH   = 32;
  localparam int FIB_WIDTH   = 32;
  localparam int MEFF_WIDTH  = VALUE_WIDTH + 1;
  localparam int CMP_WIDTH   = MOD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;
  localparam int CNT_WIDTH   = $clog2(SUM_WIDTH);

  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1000000007);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [3:0][VALUE_WIDTH-1:0] mat_t;

  // entry index 0 is upper left, row major
  localparam mat_t BASE_INIT = {VALUE_WIDTH'(0), VALUE_WIDTH'(1),
                                VALUE_WIDTH'(1), VALUE_WIDTH'(1)};
  localparam mat_t ACC_INIT  = {VALUE_WIDTH'(1), VALUE_WIDTH'(0),
                                VALUE_WIDTH'(0), VALUE_WIDTH'(1)};

  localparam logic [1:0] ENTRY_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DOT_IDLE,
    DOT_MUL_B,
    DOT_ADD,
    DOT_RED
  } dot_state_t;

  typedef struct packed {
    logic   start;
    value_t a;
    value_t b;
    value_t c;
    value_t d;
  } dot_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    value_t value;
  } dot_sts_t;

endpackage

// ===== hdl/fmmp_exp_if.sv =====
// ----------------------------------------------------------------------------
// fmmp_exp_if
// exponent bit channel: one item per bit, least significant first
// ----------------------------------------------------------------------------
interface fmmp_exp_if;

  logic valid;
  logic ready;
  logic exp_bit;
  logic last_bit;

  modport source (output valid, output exp_bit, output last_bit, input ready);
  modport sink (input valid, input exp_bit, input last_bit, output ready);

endinterface

// ===== hdl/fmmp_result_if.sv =====
// ----------------------------------------------------------------------------
// fmmp_result_if
// result channel: one item per exponent
// ----------------------------------------------------------------------------
interface fmmp_result_if;

  logic        valid;
  logic        ready;
  logic [31:0] fib_value;

  modport source (output valid, output fib_value, input ready);
  modport sink (input valid, input fib_value, output ready);

endinterface

// ===== hdl/fmmp_dot_unit.sv =====
// ----------------------------------------------------------------------------
// fmmp_dot_unit
// (a*b + c*d) mod m: one shared multiplier, then a shift-subtract
// reducer that takes one bit of the full-width sum per cycle
// ----------------------------------------------------------------------------
module fmmp_dot_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  fmmp_pkg::dot_req_t                 req,
  input  logic [fmmp_pkg::MEFF_WIDTH-1:0]    m_eff,
  output fmmp_pkg::dot_sts_t                 sts
);
  import fmmp_pkg::*;

  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(SUM_WIDTH - 1);

  dot_state_t state;
  dot_state_t state_next;

  value_t                  c_q;
  value_t                  d_q;
  logic [PROD_WIDTH-1:0]   prod;
  logic [SUM_WIDTH-1:0]    sum;
  logic [MEFF_WIDTH-1:0]   rem;
  logic [CNT_WIDTH-1:0]    cnt;
  logic                    done;
  value_t                  value;

  value_t                  mul_a;
  value_t                  mul_b;
  logic [PROD_WIDTH-1:0]   mul_out;
  logic [MEFF_WIDTH:0]     trial;
  logic [MEFF_WIDTH-1:0]   rem_next;

  assign mul_a   = (state == DOT_IDLE) ? req.a : c_q;
  assign mul_b   = (state == DOT_IDLE) ? req.b : d_q;
  assign mul_out = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

  always_comb begin
    trial = {rem, sum[SUM_WIDTH-1]};
    if (trial >= {1'b0, m_eff}) begin
      rem_next = MEFF_WIDTH'(trial - {1'b0, m_eff});
    end else begin
      rem_next = MEFF_WIDTH'(trial);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DOT_IDLE: begin
        if (req.start) begin
          state_next = DOT_MUL_B;
        end
      end
      DOT_MUL_B: state_next = DOT_ADD;
      DOT_ADD:   state_next = DOT_RED;
      DOT_RED: begin
        if (cnt == CNT_LAST) begin
          state_next = DOT_IDLE;
        end
      end
      default: state_next = DOT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DOT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == DOT_RED) && (cnt == CNT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DOT_IDLE: begin
        if (req.start) begin
          prod <= mul_out;
          c_q  <= req.c;
          d_q  <= req.d;
        end
      end
      DOT_MUL_B: begin
        prod <= mul_out;
        sum  <= SUM_WIDTH'(prod);
      end
      DOT_ADD: begin
        sum <= sum + SUM_WIDTH'(prod);
        rem <= '0;
        cnt <= '0;
      end
      DOT_RED: begin
        rem <= rem_next;
        sum <= sum << 1;
        cnt <= cnt + CNT_WIDTH'(1);
        if (cnt == CNT_LAST) begin
          value <= rem_next[VALUE_WIDTH-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.busy  = (state != DOT_IDLE);
  assign sts.done  = done;
  assign sts.value = value;

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == DOT_IDLE))
    else $error("dot unit started while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("dot unit done held longer than one cycle");

  a_done_after_red: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == DOT_RED))
    else $error("dot unit done without a reduction pass");

endmodule

// ===== hdl/fibonacci_mod_matrix_power.sv =====
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power
// F(n) mod m by square-and-multiply on the 2x2 fibonacci matrix
//
//   channel    dir   payload                 handshake
//   exp_item   in    exp_bit, last_bit       valid/ready
//   result     out   fib_value[31:0]         valid/ready
//   cfg        in    cfg_wdata[31:0]         cfg_we (modulus)
//
// each matrix entry is one pass through the shared dot unit, whose
// 65-step shift-subtract reducer takes one sum bit per cycle
// a 0 bit squares only (4 entries), a 1 bit multiplies and squares
// (8 entries); ready is low meanwhile
// a result waits in an output register; a new item is taken while it waits
// rst is synchronous: matrices, modulus and control return to reset values
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power (
  input  logic                             clk,
  input  logic                             rst,
  fmmp_exp_if.sink                         exp_item,
  fmmp_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [fmmp_pkg::MOD_WIDTH-1:0]   cfg_wdata
);
  import fmmp_pkg::*;

  localparam logic [CMP_WIDTH-1:0] FULL_MOD = CMP_WIDTH'(1) << VALUE_WIDTH;

  state_t state;
  state_t state_next;

  logic [MOD_WIDTH-1:0]   modulus;
  logic [MEFF_WIDTH-1:0]  m_eff;
  logic [CMP_WIDTH-1:0]   m_ext;

  mat_t                       base;
  mat_t                       acc;
  logic [2:0][VALUE_WIDTH-1:0] tmp;
  logic [1:0]                 entry;
  logic                       phase_acc;
  logic                       last_q;
  logic                       start;
  logic                       out_valid;
  logic [FIB_WIDTH-1:0]       fib_q;

  mat_t     left;
  dot_req_t dot_req;
  dot_sts_t dot_sts;
  logic     accept;
  logic     load_out;

  // zero or oversize modulus means plain wrap at the value width
  always_comb begin
    m_ext = {1'b0, modulus};
    if ((modulus == '0) || (m_ext > FULL_MOD)) begin
      m_eff = MEFF_WIDTH'(FULL_MOD);
    end else begin
      m_eff = MEFF_WIDTH'(m_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  assign left = phase_acc ? acc : base;

  always_comb begin
    dot_req.start = start;
    case (entry)
      2'd0: begin
        dot_req.a = left[0];
        dot_req.b = base[0];
        dot_req.c = left[1];
        dot_req.d = base[2];
      end
      2'd1: begin
        dot_req.a = left[0];
        dot_req.b = base[1];
        dot_req.c = left[1];
        dot_req.d = base[3];
      end
      2'd2: begin
        dot_req.a = left[2];
        dot_req.b = base[0];
        dot_req.c = left[3];
        dot_req.d = base[2];
      end
      default: begin
        dot_req.a = left[2];
        dot_req.b = base[1];
        dot_req.c = left[3];
        dot_req.d = base[3];
      end
    endcase
  end

  fmmp_dot_unit u_dot (
    .clk   (clk),
    .rst   (rst),
    .req   (dot_req),
    .m_eff (m_eff),
    .sts   (dot_sts)
  );

  always_comb begin
    state_next     = state;
    exp_item.ready = 1'b0;
    load_out       = 1'b0;
    case (state)
      ST_IDLE: begin
        exp_item.ready = 1'b1;
        if (exp_item.valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (dot_sts.done && (entry == ENTRY_LAST) && !phase_acc) begin
          state_next = last_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = exp_item.valid && exp_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= BASE_INIT;
      acc       <= ACC_INIT;
      entry     <= '0;
      phase_acc <= 1'b0;
      last_q    <= 1'b0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= ((state == ST_IDLE) && accept) ||
               ((state == ST_RUN) && dot_sts.done &&
                ((entry != ENTRY_LAST) || phase_acc));
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase_acc <= exp_item.exp_bit;
            last_q    <= exp_item.last_bit;
            entry     <= '0;
          end
        end
        ST_RUN: begin
          if (dot_sts.done) begin
            if (entry == ENTRY_LAST) begin
              if (phase_acc) begin
                acc       <= {dot_sts.value, tmp[2], tmp[1], tmp[0]};
                phase_acc <= 1'b0;
                entry     <= '0;
              end else begin
                base  <= {dot_sts.value, tmp[2], tmp[1], tmp[0]};
                entry <= '0;
              end
            end else begin
              entry <= entry + 2'd1;
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            base <= BASE_INIT;
            acc  <= ACC_INIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RUN) && dot_sts.done && (entry != ENTRY_LAST)) begin
      tmp[entry] <= dot_sts.value;
    end
    if (load_out) begin
      fib_q <= FIB_WIDTH'(acc[1]);
    end
  end

  assign result.valid     = out_valid;
  assign result.fib_value = fib_q;

  a_ready_dot_idle: assert property (@(posedge clk) disable iff (rst)
    exp_item.ready |-> !dot_sts.busy)
    else $error("ready while the dot unit is busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    dot_sts.done |-> (state == ST_RUN))
    else $error("dot result outside a matrix product");

  a_done_state_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> last_q)
    else $error("result pending for an item not marked last");

  a_acc_before_square: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && dot_sts.done && phase_acc && (entry == ENTRY_LAST))
      |=> (start && !phase_acc))
    else $error("square did not follow the accumulator product");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fibonacci mod-m matrix power block: exponent
// bits go in lsb first, each finished exponent is checked against a
// square-and-multiply predictor, with modulus changes and random stalls
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fmmp_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 700;
  localparam int HOLD_CYCLES   = 4000;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 426;
  localparam int DIR_ROWS      = 23;

  typedef struct packed {
    bit     wr_mod;
    value_t mod_val;
    bit     exp_bit;
    bit     last_bit;
    bit     known;
    value_t fib_known;
  } dir_row_t;

  // n = 0, 1, 2, 3, 4 at reset modulus, then modulus one, wraparound,
  // all-ones modulus and a change in the middle of an exponent
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, 32'd0,          1'b0, 1'b1, 1'b1, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b1, 1'b1, 32'd1},
    '{1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b1, 1'b1, 32'd1},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b1, 1'b1, 32'd2},
    '{1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b0, 1'b1, 1'b1, 32'd3},
    '{1'b1, 32'd1,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b1, 1'b1, 32'd0},
    '{1'b1, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b1, 1'b0, 32'd0},
    '{1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b1, 32'd7,          1'b1, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0,          1'b1, 1'b1, 1'b0, 32'd0}
  };

  localparam int SRC_IDLE [3] = '{23, 51, 0};
  localparam int SNK_IDLE [3] = '{51, 23, 0};

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [MOD_WIDTH-1:0] cfg_wdata = '0;

  fmmp_exp_if    exp_item ();
  fmmp_result_if result ();

  fibonacci_mod_matrix_power u_dut (
    .clk       (clk),
    .rst       (rst),
    .exp_item  (exp_item),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  value_t modulus_q = MODULUS_RESET;
  mat_t   base_m    = BASE_INIT;
  mat_t   acc_m     = ACC_INIT;
  value_t fib_expected_q [$];
  int     mismatches   = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  bit     hold_req     = 1'b0;

  function automatic logic [63:0] eff_modulus();
    return (modulus_q == '0) ? 64'h1_0000_0000 : 64'(modulus_q);
  endfunction

  function automatic value_t mod_dot(value_t a, value_t b, value_t c, value_t d,
                                     logic [63:0] m);
    logic [63:0] s;
    s = (64'(a) * 64'(b)) % m + (64'(c) * 64'(d)) % m;
    return value_t'(s % m);
  endfunction

  function automatic mat_t mat_product(mat_t l, mat_t r, logic [63:0] m);
    mat_t p;
    p[0] = mod_dot(l[0], r[0], l[1], r[2], m);
    p[1] = mod_dot(l[0], r[1], l[1], r[3], m);
    p[2] = mod_dot(l[2], r[0], l[3], r[2], m);
    p[3] = mod_dot(l[2], r[1], l[3], r[3], m);
    return p;
  endfunction

  // advance the predicted matrices by one exponent bit
  task automatic fib_step(bit e, bit l, bit known, value_t known_val);
    logic [63:0] m;
    m = eff_modulus();
    if (e) acc_m = mat_product(acc_m, base_m, m);
    base_m = mat_product(base_m, base_m, m);
    if (l) begin
      fib_expected_q.push_back(known ? known_val : acc_m[1]);
      acc_m  = ACC_INIT;
      base_m = BASE_INIT;
    end
  endtask

  task automatic send_bit(bit e, bit l, bit known, value_t known_val);
    while ($urandom_range(99) < src_idle_pct) begin
      exp_item.valid <= 1'b0;
      @(posedge clk);
    end
    exp_item.valid    <= 1'b1;
    exp_item.exp_bit  <= e;
    exp_item.last_bit <= l;
    do @(posedge clk); while (exp_item.ready !== 1'b1);
    fib_step(e, l, known, known_val);
  endtask

  task automatic set_modulus(value_t m);
    exp_item.valid <= 1'b0;
    while (fib_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    modulus_q = m;
  endtask

  function automatic int exp_length();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 24) : $urandom_range(10, 1);
  endfunction

  initial begin : stimulus
    int     len;
    int     sent;
    bit     mid_done;
    value_t phase_mod [3];
    value_t mid_mod [3];
    exp_item.valid    = 1'b0;
    exp_item.exp_bit  = 1'b0;
    exp_item.last_bit = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].wr_mod) set_modulus(DIR_TAB[r].mod_val);
      send_bit(DIR_TAB[r].exp_bit, DIR_TAB[r].last_bit, DIR_TAB[r].known,
               DIR_TAB[r].fib_known);
    end

    phase_mod = '{32'hFFFF_FFFF, 32'd0, MODULUS_RESET};
    mid_mod   = '{$urandom(), $urandom_range(50, 2), $urandom_range(1000, 3)};
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = SRC_IDLE[ph];
      snk_idle_pct = SNK_IDLE[ph];
      set_modulus(phase_mod[ph]);
      // long receiver hold-off while short exponents keep coming
      if (ph == 2) hold_req <= 1'b1;
      sent     = 0;
      mid_done = 1'b0;
      while (sent < PHASE_ITEMS) begin
        len = (ph == 2 && sent < 40) ? 1 : exp_length();
        for (int i = 0; i < len; i++) begin
          if (!mid_done && i > 0 && sent >= PHASE_ITEMS / 2) begin
            set_modulus(mid_mod[ph]);
            mid_done = 1'b1;
          end
          send_bit(1'($urandom_range(1)), i == len - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    exp_item.valid <= 1'b0;
    while (fib_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_sink
    int     hold_left;
    value_t want;
    hold_left    = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (fib_expected_q.size() == 0) begin
          $error("fib_value: no result expected, got %0d", result.fib_value);
          mismatches++;
        end else begin
          want = fib_expected_q.pop_front();
          if (result.fib_value !== want) begin
            $error("fib_value: expected %0d, got %0d", want, result.fib_value);
            mismatches++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((exp_item.valid === 1'b1 && exp_item.ready === 1'b1) ||
          (result.valid === 1'b1 && result.ready === 1'b1)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("simulation failed");
    $finish;
  end

endmodule
